// ===== design/lbkm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbkm_pkg: shared types and constants for the Lab background key mask
// Holds register indexes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lbkm_pkg;

    // Frame geometry
    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int FRAME_W    = 13;
    localparam int MARGIN_W   = 12;

    // Pixel and mask widths
    localparam int PIX_W      = 8;
    localparam int THR_W      = 9;
    localparam logic [PIX_W-1:0] MASK_FULL = 8'hFF;
    localparam logic [PIX_W-1:0] MASK_NONE = 8'h00;

    // Ramp divider: one quotient bit per step
    localparam int DIV_STEPS  = PIX_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AB_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L_LOWER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L_UPPER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H    = 3'd6;

    // Live configuration, frame sizes already reduced to last index
    typedef struct packed {
        logic [PIX_W-1:0]    bg_l;
        logic [PIX_W-1:0]    bg_a;
        logic [PIX_W-1:0]    bg_b;
        logic [THR_W-1:0]    ab_thr;
        logic [PIX_W-1:0]    l_lower;
        logic [PIX_W-1:0]    l_upper;
        logic [MARGIN_W-1:0] margin;
        logic [DIM_W-1:0]    col_last;
        logic [DIM_W-1:0]    row_last;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load_pix;
        logic calc_dist;
        logic decide;
        logic div_step;
        logic update;
        logic box_clamp;
        logic box_size;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic frame_end;
    } t_stat;

endpackage

// ===== design/lab_background_key_mask_with_bbox.sv =====
// ----------------------------------------------------------------------------
// lab_background_key_mask_with_bbox: Lab key mask with crop rectangle
//
//   Channel   Handshake            Payload
//   pixel in  i_valid / o_ready    i_lum, i_chroma_a, i_chroma_b
//   result    o_valid / i_ready    o_mask, o_frame_done, o_mask_was_empty,
//                                  o_box_x, o_box_y, o_box_width, o_box_height
//   config    i_cfg_we             i_cfg_index, i_cfg_data
//
// One pixel is in work at a time. The mask is decided by the chroma test or
// the ramp limits, or the ramp value goes through the eight-step restoring
// divider; on the last pixel of a frame the crop rectangle is computed as
// well. The input is ready again the cycle after write-back. A result waits
// in the output register; the next pixel is taken meanwhile and stalls at
// write-back only if the previous result is still untaken. Reset is
// synchronous and brings the registers to their defaults and the counters
// and box to frame start.
// ----------------------------------------------------------------------------
module lab_background_key_mask_with_bbox (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lbkm_pkg::PIX_W-1:0]       i_lum,
    input  logic [lbkm_pkg::PIX_W-1:0]       i_chroma_a,
    input  logic [lbkm_pkg::PIX_W-1:0]       i_chroma_b,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lbkm_pkg::PIX_W-1:0]       o_mask,
    output logic                             o_frame_done,
    output logic                             o_mask_was_empty,
    output logic [lbkm_pkg::DIM_W-1:0]       o_box_x,
    output logic [lbkm_pkg::DIM_W-1:0]       o_box_y,
    output logic [lbkm_pkg::DIM_W-1:0]       o_box_width,
    output logic [lbkm_pkg::DIM_W-1:0]       o_box_height,
    input  logic                             i_cfg_we,
    input  logic [lbkm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbkm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lbkm_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    lbkm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lbkm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lbkm_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_lum            (i_lum),
        .i_chroma_a       (i_chroma_a),
        .i_chroma_b       (i_chroma_b),
        .o_mask           (o_mask),
        .o_frame_done     (o_frame_done),
        .o_mask_was_empty (o_mask_was_empty),
        .o_box_x          (o_box_x),
        .o_box_y          (o_box_y),
        .o_box_width      (o_box_width),
        .o_box_height     (o_box_height)
    );

endmodule

// ===== design/lbkm_cfg.sv =====
// ----------------------------------------------------------------------------
// lbkm_cfg: configuration register file
// Write-only registers; frame sizes are stored as their clamped last index.
// ----------------------------------------------------------------------------
module lbkm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbkm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbkm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lbkm_pkg::t_cfg                   o_cfg
);
    import lbkm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Map a frame size to its last index: zero counts as one, large clamps
    function automatic logic [DIM_W-1:0] last_index(input logic [FRAME_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > FRAME_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(v - FRAME_W'(1));
        end
        return res;
    endfunction

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BG_COLOR: begin
                    n_cfg.bg_l = i_cfg_data[23:16];
                    n_cfg.bg_a = i_cfg_data[15:8];
                    n_cfg.bg_b = i_cfg_data[7:0];
                end
                CFG_AB_THR:  n_cfg.ab_thr   = i_cfg_data[THR_W-1:0];
                CFG_L_LOWER: n_cfg.l_lower  = i_cfg_data[PIX_W-1:0];
                CFG_L_UPPER: n_cfg.l_upper  = i_cfg_data[PIX_W-1:0];
                CFG_MARGIN:  n_cfg.margin   = i_cfg_data[MARGIN_W-1:0];
                CFG_FRAME_W: n_cfg.col_last = last_index(i_cfg_data[FRAME_W-1:0]);
                CFG_FRAME_H: n_cfg.row_last = last_index(i_cfg_data[FRAME_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bg_l     <= '0;
            r_cfg.bg_a     <= '0;
            r_cfg.bg_b     <= '0;
            r_cfg.ab_thr   <= '0;
            r_cfg.l_lower  <= '0;
            r_cfg.l_upper  <= MASK_FULL;
            r_cfg.margin   <= '0;
            r_cfg.col_last <= DIM_W'(MAX_DIM - 1);
            r_cfg.row_last <= DIM_W'(MAX_DIM - 1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/lbkm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbkm_ctrl: sequencer for one pixel at a time
// Steps the datapath through distance, decision, division, box update, crop
// clamp and sizing, and write-back, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module lbkm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lbkm_pkg::t_stat i_stat,
    output lbkm_pkg::t_cmd  o_cmd
);
    import lbkm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIST   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_CLAMP  = 3'd5;
    localparam logic [2:0] S_SIZE   = 3'd6;
    localparam logic [2:0] S_WB     = 3'd7;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_cmd                 cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_pix = 1'b1;
                    n_state      = S_DIST;
                end
            end
            S_DIST: begin
                cmd.calc_dist = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                n_cnt      = '0;
                n_state    = i_stat.need_div ? S_DIV : S_UPDATE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_cnt = r_cnt + DIV_CNT_W'(1);
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                n_state    = i_stat.frame_end ? S_CLAMP : S_WB;
            end
            S_CLAMP: begin
                cmd.box_clamp = 1'b1;
                n_state       = S_SIZE;
            end
            S_SIZE: begin
                cmd.box_size = 1'b1;
                n_state      = S_WB;
            end
            S_WB: begin
                // Wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on write-back, drop when the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== design/lbkm_dpath.sv =====
// ----------------------------------------------------------------------------
// lbkm_dpath: mask and bounding box datapath
// Pixel registers, color distances, restoring ramp divider, raster counters,
// running box, crop rectangle and the output register.
// ----------------------------------------------------------------------------
module lbkm_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbkm_pkg::t_cfg              i_cfg,
    input  lbkm_pkg::t_cmd              i_cmd,
    output lbkm_pkg::t_stat             o_stat,
    input  logic [lbkm_pkg::PIX_W-1:0]  i_lum,
    input  logic [lbkm_pkg::PIX_W-1:0]  i_chroma_a,
    input  logic [lbkm_pkg::PIX_W-1:0]  i_chroma_b,
    output logic [lbkm_pkg::PIX_W-1:0]  o_mask,
    output logic                        o_frame_done,
    output logic                        o_mask_was_empty,
    output logic [lbkm_pkg::DIM_W-1:0]  o_box_x,
    output logic [lbkm_pkg::DIM_W-1:0]  o_box_y,
    output logic [lbkm_pkg::DIM_W-1:0]  o_box_width,
    output logic [lbkm_pkg::DIM_W-1:0]  o_box_height
);
    import lbkm_pkg::*;

    localparam int SUM_W = DIM_W + 1;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Pixel and distance registers
    logic [PIX_W-1:0] r_lum, r_ca, r_cb;
    logic [PIX_W-1:0] r_dl, r_da, r_db;

    // Divider and mask
    logic [PIX_W-1:0] r_rem, r_num_lo, r_div, r_mask;

    // Raster counters and running box
    logic [DIM_W-1:0] r_col, r_row;
    logic [DIM_W-1:0] r_left, r_right, r_top, r_bottom;
    logic             r_any;
    logic             r_frame_end;

    // Crop rectangle
    logic [DIM_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [DIM_W-1:0] r_bx, r_by, r_bw, r_bh;

    // Decision terms
    logic [THR_W-1:0]   ab_sum;
    logic               chroma_fg, step_ramp, ramp_lo, ramp_hi, need_div;
    logic [PIX_W-1:0]   fixed_mask, ramp_diff;
    logic [2*PIX_W-1:0] ramp_num;

    // Divider step
    logic [PIX_W:0]   trial;
    logic             q_bit;

    // Raster position
    logic             row_end, last_row, frame_end;
    logic [DIM_W-1:0] pos_u, pos_v;

    // Clamp terms
    logic [SUM_W-1:0] x_far, y_far;

    // Classify the pixel from its distances
    always_comb begin
        ab_sum    = {1'b0, r_da} + {1'b0, r_db};
        chroma_fg = ({1'b0, r_da} > i_cfg.ab_thr) || ({1'b0, r_db} > i_cfg.ab_thr)
                    || (ab_sum > i_cfg.ab_thr);
        step_ramp = (i_cfg.l_upper <= i_cfg.l_lower);
        ramp_lo   = (r_dl <= i_cfg.l_lower);
        ramp_hi   = (r_dl >= i_cfg.l_upper);
        need_div  = !chroma_fg && !step_ramp && !ramp_lo && !ramp_hi;
        if (chroma_fg) begin
            fixed_mask = MASK_FULL;
        end else if (step_ramp) begin
            fixed_mask = (r_dl > i_cfg.l_lower) ? MASK_FULL : MASK_NONE;
        end else if (ramp_lo) begin
            fixed_mask = MASK_NONE;
        end else begin
            fixed_mask = MASK_FULL;
        end
        // 255 * diff as a shift and subtract
        ramp_diff = r_dl - i_cfg.l_lower;
        ramp_num  = {ramp_diff, MASK_NONE} - {MASK_NONE, ramp_diff};
    end

    // One restoring division step
    always_comb begin
        trial = {r_rem, r_num_lo[PIX_W-1]};
        q_bit = (trial >= {1'b0, r_div});
    end

    // Raster position of this pixel
    always_comb begin
        row_end   = (r_col >= i_cfg.col_last);
        last_row  = (r_row >= i_cfg.row_last);
        frame_end = row_end && last_row;
        pos_u     = row_end ? i_cfg.col_last : r_col;
        pos_v     = last_row ? i_cfg.row_last : r_row;
    end

    // Far edges of the widened box
    always_comb begin
        x_far = {1'b0, r_right} + SUM_W'(i_cfg.margin) + SUM_W'(1);
        y_far = {1'b0, r_bottom} + SUM_W'(i_cfg.margin) + SUM_W'(1);
    end

    // Capture the pixel and compute distances
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_lum <= i_lum;
            r_ca  <= i_chroma_a;
            r_cb  <= i_chroma_b;
        end
        if (i_cmd.calc_dist) begin
            r_dl <= abs_diff(r_lum, i_cfg.bg_l);
            r_da <= abs_diff(r_ca, i_cfg.bg_a);
            r_db <= abs_diff(r_cb, i_cfg.bg_b);
        end
    end

    // Decide the mask or load the divider; shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_mask   <= need_div ? MASK_NONE : fixed_mask;
            r_rem    <= ramp_num[2*PIX_W-1:PIX_W];
            r_num_lo <= ramp_num[PIX_W-1:0];
            r_div    <= i_cfg.l_upper - i_cfg.l_lower;
        end else if (i_cmd.div_step) begin
            r_rem    <= q_bit ? PIX_W'(trial - {1'b0, r_div}) : trial[PIX_W-1:0];
            r_num_lo <= {r_num_lo[PIX_W-2:0], 1'b0};
            r_mask   <= {r_mask[PIX_W-2:0], q_bit};
        end
    end

    // Advance the raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.update) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= pos_v + DIM_W'(1);
            end else begin
                r_col <= pos_u + DIM_W'(1);
            end
        end
    end

    // Grow the box; drop it once the frame result is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else if (i_cmd.update && (r_mask != MASK_NONE)) begin
            r_any <= 1'b1;
        end else if (i_cmd.load_out && r_frame_end) begin
            r_any <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_frame_end <= frame_end;
            if (r_mask != MASK_NONE) begin
                if (!r_any || (pos_u < r_left))   r_left   <= pos_u;
                if (!r_any || (pos_u > r_right))  r_right  <= pos_u;
                if (!r_any || (pos_v < r_top))    r_top    <= pos_v;
                if (!r_any || (pos_v > r_bottom)) r_bottom <= pos_v;
            end
        end
    end

    // Widen by the margin and clamp to the frame
    always_ff @(posedge i_clk) begin
        if (i_cmd.box_clamp) begin
            r_x0 <= (r_left > i_cfg.margin) ? DIM_W'(r_left - i_cfg.margin) : '0;
            r_y0 <= (r_top > i_cfg.margin) ? DIM_W'(r_top - i_cfg.margin) : '0;
            r_x1 <= (x_far > {1'b0, i_cfg.col_last}) ? i_cfg.col_last : x_far[DIM_W-1:0];
            r_y1 <= (y_far > {1'b0, i_cfg.row_last}) ? i_cfg.row_last : y_far[DIM_W-1:0];
        end
    end

    // Size the rectangle; an empty mask gives the whole frame less one
    always_ff @(posedge i_clk) begin
        if (i_cmd.box_size) begin
            if (r_any) begin
                r_bx <= r_x0;
                r_by <= r_y0;
                r_bw <= (r_x1 >= r_x0) ? (r_x1 - r_x0) : '0;
                r_bh <= (r_y1 >= r_y0) ? (r_y1 - r_y0) : '0;
            end else begin
                r_bx <= '0;
                r_by <= '0;
                r_bw <= i_cfg.col_last;
                r_bh <= i_cfg.row_last;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mask           <= r_mask;
            o_frame_done     <= r_frame_end;
            o_mask_was_empty <= r_frame_end && !r_any;
            o_box_x          <= r_frame_end ? r_bx : '0;
            o_box_y          <= r_frame_end ? r_by : '0;
            o_box_width      <= r_frame_end ? r_bw : '0;
            o_box_height     <= r_frame_end ? r_bh : '0;
        end
    end

    assign o_stat.need_div  = need_div;
    assign o_stat.frame_end = frame_end;

endmodule

// ===== design/lbkm_checker.sv =====
// ----------------------------------------------------------------------------
// lbkm_checker: port-level checks for the key mask block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module lbkm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [lbkm_pkg::PIX_W-1:0]       o_mask,
    input  logic                             o_frame_done,
    input  logic                             o_mask_was_empty,
    input  logic [lbkm_pkg::DIM_W-1:0]       o_box_x,
    input  logic [lbkm_pkg::DIM_W-1:0]       o_box_y,
    input  logic [lbkm_pkg::DIM_W-1:0]       o_box_width,
    input  logic [lbkm_pkg::DIM_W-1:0]       o_box_height
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mask) && $stable(o_frame_done)
            && $stable(o_box_x) && $stable(o_box_width))
        else $error("result changed while stalled");

    // One pixel in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("pixel accepted while another is in work");

    // Box fields are zero except on the last pixel
    a_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |-> !o_mask_was_empty && (o_box_x == '0)
            && (o_box_y == '0) && (o_box_width == '0) && (o_box_height == '0))
        else $error("box fields set on a pixel that does not end the frame");

    // An empty mask crops from the origin
    a_empty_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mask_was_empty |-> o_frame_done && (o_box_x == '0)
            && (o_box_y == '0))
        else $error("empty mask without origin crop");

endmodule

bind lab_background_key_mask_with_bbox lbkm_checker u_lbkm_checker (.*);

// ===== tb/lab_background_key_mask_with_bbox_tb.sv =====
// ----------------------------------------------------------------------------
// lab_background_key_mask_with_bbox_tb: self-checking bench for the Lab key mask
// Streams pixels over valid/ready and predicts each mask byte and the crop
// rectangle with an in-bench model of the counters and the bounding box.
// Checks every result in order. Covers directed ramp, chroma, empty-mask and
// margin cases, then random frames with random settings, idles on both sides,
// and a long output stall.
// ----------------------------------------------------------------------------
module lab_background_key_mask_with_bbox_tb;
    import lbkm_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int BASE_IDLE    = 26;

    typedef struct packed {
        logic [PIX_W-1:0] mask;
        logic             frame_done;
        logic             was_empty;
        logic [DIM_W-1:0] box_x, box_y, box_w, box_h;
    } t_mask_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_lum = '0;
    logic [PIX_W-1:0]      i_chroma_a = '0;
    logic [PIX_W-1:0]      i_chroma_b = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PIX_W-1:0]      o_mask;
    logic                  o_frame_done;
    logic                  o_mask_was_empty;
    logic [DIM_W-1:0]      o_box_x;
    logic [DIM_W-1:0]      o_box_y;
    logic [DIM_W-1:0]      o_box_width;
    logic [DIM_W-1:0]      o_box_height;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Register shadows
    int reg_bg_color;
    int reg_ab_thr;
    int reg_l_lower;
    int reg_l_upper;
    int reg_margin;
    int reg_frame_w;
    int reg_frame_h;

    // Raster position and running box
    int col_cnt;
    int row_cnt;
    int box_left;
    int box_right;
    int box_top;
    int box_bottom;
    bit any_fg;

    t_mask_result pending_masks[$];
    t_mask_result seen_res;
    t_mask_result want_res;
    int           err_count = 0;
    int           pixels_sent = 0;
    int           src_idle_pct = BASE_IDLE;
    int           snk_idle_pct = BASE_IDLE;
    int           hold_req = 0;
    int           hold_seq = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    lab_background_key_mask_with_bbox u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_lum            (i_lum),
        .i_chroma_a       (i_chroma_a),
        .i_chroma_b       (i_chroma_b),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_mask           (o_mask),
        .o_frame_done     (o_frame_done),
        .o_mask_was_empty (o_mask_was_empty),
        .o_box_x          (o_box_x),
        .o_box_y          (o_box_y),
        .o_box_width      (o_box_width),
        .o_box_height     (o_box_height),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int clip_dim(input int v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_byte(input int v);
        if (v < 0) return '0;
        if (v > 255) return MASK_FULL;
        return v[PIX_W-1:0];
    endfunction

    // Return counters and box to frame start
    function automatic void restart_frame();
        col_cnt    = 0;
        row_cnt    = 0;
        box_left   = clip_dim(reg_frame_w) - 1;
        box_right  = 0;
        box_top    = clip_dim(reg_frame_h) - 1;
        box_bottom = 0;
        any_fg     = 1'b0;
    endfunction

    // Key one pixel, advance the raster position, and build the result
    function automatic t_mask_result key_and_track(input logic [PIX_W-1:0] lum,
                                                   input logic [PIX_W-1:0] ca,
                                                   input logic [PIX_W-1:0] cb);
        int           w, h, dl, da, db, m, u, v, mx, my, bx, by, bw, bh;
        bit           row_end, frame_end;
        t_mask_result r;
        w  = clip_dim(reg_frame_w);
        h  = clip_dim(reg_frame_h);
        dl = abs_diff(int'(lum), (reg_bg_color >> 16) & 'hFF);
        da = abs_diff(int'(ca), (reg_bg_color >> 8) & 'hFF);
        db = abs_diff(int'(cb), reg_bg_color & 'hFF);
        if (da > reg_ab_thr || db > reg_ab_thr || da + db > reg_ab_thr) begin
            m = 255;
        end else if (reg_l_upper <= reg_l_lower) begin
            m = (dl > reg_l_lower) ? 255 : 0;
        end else if (dl <= reg_l_lower) begin
            m = 0;
        end else if (dl >= reg_l_upper) begin
            m = 255;
        end else begin
            m = (255 * (dl - reg_l_lower)) / (reg_l_upper - reg_l_lower);
        end

        row_end   = (col_cnt >= w - 1);
        frame_end = row_end && (row_cnt >= h - 1);
        u = row_end ? w - 1 : col_cnt;
        v = (row_cnt >= h - 1) ? h - 1 : row_cnt;

        // Grow the box on any nonzero mask
        if (m != 0) begin
            if (!any_fg) begin
                box_left   = u;
                box_right  = u;
                box_top    = v;
                box_bottom = v;
            end else begin
                if (u < box_left)   box_left   = u;
                if (u > box_right)  box_right  = u;
                if (v < box_top)    box_top    = v;
                if (v > box_bottom) box_bottom = v;
            end
            any_fg = 1'b1;
        end

        r      = '0;
        r.mask = m[PIX_W-1:0];
        if (frame_end) begin
            if (any_fg) begin
                mx = box_right + reg_margin + 1;
                my = box_bottom + reg_margin + 1;
                if (mx > w - 1) mx = w - 1;
                if (my > h - 1) my = h - 1;
                bx = (box_left > reg_margin) ? box_left - reg_margin : 0;
                by = (box_top > reg_margin) ? box_top - reg_margin : 0;
                bw = (mx >= bx) ? mx - bx : 0;
                bh = (my >= by) ? my - by : 0;
            end else begin
                bx = 0;
                by = 0;
                bw = w - 1;
                bh = h - 1;
            end
            r.frame_done = 1'b1;
            r.was_empty  = !any_fg;
            r.box_x      = bx[DIM_W-1:0];
            r.box_y      = by[DIM_W-1:0];
            r.box_w      = bw[DIM_W-1:0];
            r.box_h      = bh[DIM_W-1:0];
            restart_frame();
        end else if (row_end) begin
            col_cnt = 0;
            row_cnt = v + 1;
        end else begin
            col_cnt = u + 1;
        end
        return r;
    endfunction

    // Pick a pixel: background, random, or near the ramp and chroma limits
    function automatic logic [23:0] pick_pixel(input int fg_pct);
        int          span, cspan;
        logic [23:0] px;
        px = reg_bg_color[23:0];
        if ($urandom_range(0, 99) < fg_pct) begin
            if ($urandom_range(0, 2) == 0) begin
                px = 24'($urandom);
            end else begin
                span  = reg_l_upper + 4;
                cspan = reg_ab_thr / 2 + 3;
                px[23:16] = clamp_byte(int'(px[23:16]) + int'($urandom_range(0, 2 * span))
                                       - span);
                px[15:8]  = clamp_byte(int'(px[15:8]) + int'($urandom_range(0, 2 * cspan))
                                       - cspan);
                px[7:0]   = clamp_byte(int'(px[7:0]) + int'($urandom_range(0, 2 * cspan))
                                       - cspan);
            end
        end
        return px;
    endfunction

    // Offer one item, hold it until accepted, then queue its prediction
    task automatic send_pixel(input logic [PIX_W-1:0] lum, input logic [PIX_W-1:0] ca,
                              input logic [PIX_W-1:0] cb);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_lum      <= lum;
        i_chroma_a <= ca;
        i_chroma_b <= cb;
        do @(posedge i_clk); while (!o_ready);
        pending_masks.push_back(key_and_track(lum, ca, cb));
        pixels_sent++;
    endtask

    task automatic send_packed(input logic [23:0] px);
        send_pixel(px[23:16], px[15:8], px[7:0]);
    endtask

    // Drop valid and wait for every queued result
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write one register once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BG_COLOR: reg_bg_color = value & 'hFFFFFF;
            CFG_AB_THR:   reg_ab_thr   = value & 'h1FF;
            CFG_L_LOWER:  reg_l_lower  = value & 'hFF;
            CFG_L_UPPER:  reg_l_upper  = value & 'hFF;
            CFG_MARGIN:   reg_margin   = value & 'hFFF;
            CFG_FRAME_W:  reg_frame_w  = value & 'h1FFF;
            CFG_FRAME_H:  reg_frame_h  = value & 'h1FFF;
            default: ;
        endcase
    endtask

    // Reset settings, then shrink the frame under a half-done row
    task automatic test_default_regs();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        write_reg(CFG_FRAME_W, 0);
        send_pixel(8'd0, 8'd0, 8'd0);
        write_reg(CFG_FRAME_H, 0);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    // Luminance ramp across its start, middle and end
    task automatic test_lum_ramp();
        write_reg(CFG_BG_COLOR, 'h808080);
        write_reg(CFG_AB_THR, 510);
        write_reg(CFG_L_LOWER, 10);
        write_reg(CFG_L_UPPER, 60);
        write_reg(CFG_MARGIN, 0);
        write_reg(CFG_FRAME_W, 4);
        write_reg(CFG_FRAME_H, 2);
        send_pixel(8'd128, 8'h80, 8'h80);
        send_pixel(8'd138, 8'h80, 8'h80);
        send_pixel(8'd117, 8'h80, 8'h80);
        send_pixel(8'd163, 8'h80, 8'h80);
        send_pixel(8'd69, 8'h80, 8'h80);
        send_pixel(8'd188, 8'h80, 8'h80);
        send_pixel(8'd0, 8'h80, 8'h80);
        send_pixel(8'd255, 8'h80, 8'h80);
    endtask

    // Upper limit at or below lower limit turns the ramp into a step
    task automatic test_step_ramp();
        write_reg(CFG_BG_COLOR, 0);
        write_reg(CFG_FRAME_H, 1);
        write_reg(CFG_L_LOWER, 20);
        write_reg(CFG_L_UPPER, 20);
        send_pixel(8'd20, 8'd0, 8'd0);
        send_pixel(8'd21, 8'd0, 8'd0);
        write_reg(CFG_L_LOWER, 200);
        write_reg(CFG_L_UPPER, 5);
        send_pixel(8'd200, 8'd0, 8'd0);
        send_pixel(8'd201, 8'd0, 8'd0);
    endtask

    // Chroma test on a, b and their sum, with a clamping margin
    task automatic test_chroma_key();
        write_reg(CFG_BG_COLOR, 'hFF00FF);
        write_reg(CFG_AB_THR, 5);
        write_reg(CFG_L_LOWER, 0);
        write_reg(CFG_L_UPPER, 255);
        write_reg(CFG_MARGIN, 4095);
        send_pixel(8'd255, 8'd5, 8'd255);
        send_pixel(8'd255, 8'd6, 8'd255);
        send_pixel(8'd255, 8'd3, 8'd252);
        write_reg(CFG_BG_COLOR, 'hFF0000);
        write_reg(CFG_AB_THR, 510);
        send_pixel(8'd155, 8'd255, 8'd255);
    endtask

    // Frame with no foreground at all
    task automatic test_empty_mask();
        write_reg(CFG_FRAME_W, 3);
        write_reg(CFG_MARGIN, 0);
        repeat (3) send_pixel(8'hFF, 8'h00, 8'h00);
    endtask

    // Single foreground pixel with a margin of one
    task automatic test_box_margin();
        int k;
        write_reg(CFG_BG_COLOR, 0);
        write_reg(CFG_FRAME_H, 2);
        write_reg(CFG_MARGIN, 1);
        for (k = 0; k < 6; k++) begin
            send_pixel((k == 4) ? 8'd200 : 8'd0, 8'd0, 8'd0);
        end
    endtask

    // Random settings per phase, random frames and partial frames
    task automatic test_random_frames();
        int start_cnt, fg_pct, n, lo, hi, ew, eh, k;
        bit first;
        start_cnt = pixels_sent;
        first     = 1'b1;
        while (pixels_sent - start_cnt < RANDOM_ITEMS) begin
            if (first || $urandom_range(0, 9) < 7)
                write_reg(CFG_BG_COLOR, $urandom & 'hFFFFFF);
            if (first || $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_AB_THR, 0);
                    1: write_reg(CFG_AB_THR, $urandom_range(0, 40));
                    2: write_reg(CFG_AB_THR, 510);
                    default: write_reg(CFG_AB_THR, $urandom_range(0, 511));
                endcase
            end
            if (first || $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 4))
                    0: begin lo = 0; hi = 255; end
                    1: begin lo = $urandom_range(0, 255); hi = lo; end
                    2: begin hi = $urandom_range(0, 254); lo = $urandom_range(hi, 255); end
                    default: begin
                        lo = $urandom_range(0, 200);
                        hi = $urandom_range(lo + 1, 255);
                    end
                endcase
                write_reg(CFG_L_LOWER, lo);
                write_reg(CFG_L_UPPER, hi);
            end
            if (first || $urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_MARGIN, 0);
                    1: write_reg(CFG_MARGIN, $urandom_range(1, 3));
                    2: write_reg(CFG_MARGIN, 4095);
                    default: write_reg(CFG_MARGIN, $urandom_range(0, 4095));
                endcase
            end
            if (first || $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, 99);
                if (k < 5)       write_reg(CFG_FRAME_W, 0);
                else if (k < 10) write_reg(CFG_FRAME_W, 8191);
                else if (k < 14) write_reg(CFG_FRAME_W, 4096);
                else             write_reg(CFG_FRAME_W, $urandom_range(1, 8));
            end
            if (first || $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, 99);
                if (k < 5)       write_reg(CFG_FRAME_H, 0);
                else if (k < 10) write_reg(CFG_FRAME_H, 5000);
                else if (k < 14) write_reg(CFG_FRAME_H, 4096);
                else             write_reg(CFG_FRAME_H, $urandom_range(1, 6));
            end
            first = 1'b0;

            case ($urandom_range(0, 3))
                0: fg_pct = 0;
                1: fg_pct = 3;
                2: fg_pct = 30;
                default: fg_pct = 100;
            endcase
            ew = clip_dim(reg_frame_w);
            eh = clip_dim(reg_frame_h);
            n  = $urandom_range(1, 3) * ew * eh;
            if ($urandom_range(0, 3) == 0) n = n + $urandom_range(0, ew);
            if (n > 64) n = $urandom_range(8, 64);
            for (k = 0; k < n; k++) send_packed(pick_pixel(fg_pct));
        end
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_output_stall();
        int k;
        write_reg(CFG_FRAME_W, 5);
        write_reg(CFG_FRAME_H, 3);
        src_idle_pct = 0;
        hold_req     = 200;
        hold_seq     = hold_seq + 1;
        for (k = 0; k < 40; k++) send_packed(pick_pixel(50));
        src_idle_pct = BASE_IDLE;
    endtask

    // Long run with no idling on either side
    task automatic test_back_to_back();
        int k;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (k = 0; k < 120; k++) send_packed(pick_pixel(40));
        wait_drained();
        src_idle_pct = BASE_IDLE;
        snk_idle_pct = BASE_IDLE;
    endtask

    // Receiver: random idling, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_req;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t %s: exp mask=%0d done=%0b empty=%0b box=%0d,%0d,%0d,%0d",
                     $time, what, want_res.mask, want_res.frame_done, want_res.was_empty,
                     want_res.box_x, want_res.box_y, want_res.box_w, want_res.box_h);
            $display("%0t %s: got mask=%0d done=%0b empty=%0b box=%0d,%0d,%0d,%0d",
                     $time, what, seen_res.mask, seen_res.frame_done, seen_res.was_empty,
                     seen_res.box_x, seen_res.box_y, seen_res.box_w, seen_res.box_h);
        end
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_res = {o_mask, o_frame_done, o_mask_was_empty,
                        o_box_x, o_box_y, o_box_width, o_box_height};
            if (pending_masks.size() == 0) begin
                want_res = '0;
                report_mismatch("unexpected result");
            end else begin
                want_res = pending_masks.pop_front();
                if (seen_res.mask !== want_res.mask ||
                    seen_res.frame_done !== want_res.frame_done ||
                    seen_res.was_empty !== want_res.was_empty ||
                    seen_res.box_x !== want_res.box_x ||
                    seen_res.box_y !== want_res.box_y ||
                    seen_res.box_w !== want_res.box_w ||
                    seen_res.box_h !== want_res.box_h) begin
                    report_mismatch("result mismatch");
                end
            end
        end
    end

    // Run limit
    initial begin
        #1600000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        reg_bg_color = 0;
        reg_ab_thr   = 0;
        reg_l_lower  = 0;
        reg_l_upper  = 255;
        reg_margin   = 0;
        reg_frame_w  = 4096;
        reg_frame_h  = 4096;
        restart_frame();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_regs();
        test_lum_ramp();
        test_step_ramp();
        test_chroma_key();
        test_empty_mask();
        test_box_margin();
        test_random_frames();
        test_output_stall();
        test_back_to_back();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_masks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/lbkm_pkg.sv
design/lbkm_cfg.sv
design/lbkm_ctrl.sv
design/lbkm_dpath.sv
design/lab_background_key_mask_with_bbox.sv
design/lbkm_checker.sv
tb/lab_background_key_mask_with_bbox_tb.sv
